@@ rtl/dsu_pkg.sv @@
// ----------------------------------------------------------------------------
// dsu_pkg: shared types and constants for the disjoint-set union engine
// Node index width, table depth, saturation limits and the packed table entry.
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int NODE_W  = 10;
    localparam int NODES   = 1 << NODE_W;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 11;

    localparam logic [RANK_W-1:0]  RANK_MAX  = {RANK_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // one table word per node: set size, tree rank, parent link
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [RANK_W-1:0]  rank;
        logic [NODE_W-1:0]  parent;
    } dsu_entry_t;

    localparam int ENTRY_W = $bits(dsu_entry_t);

endpackage

@@ rtl/dsu_ram.sv @@
// ----------------------------------------------------------------------------
// dsu_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/disjoint_set_union_engine.sv @@
// ----------------------------------------------------------------------------
// disjoint_set_union_engine: union-find table with union by rank and
// path compression, one request at a time through a single table RAM.
// ----------------------------------------------------------------------------
// Steps: walk node_a up to its root and point every node on that path at the
//   root, then the same for node_b; a join that merges then writes the child
//   and top root entries; link depth is at most 10 with union by rank.
// A new request is taken only in idle; busy stays high while a request runs,
//   each cycle being one read and at most one write of the table RAM ports.
// Reset: a sweep rewrites every table entry (busy high).
// done pulses for one cycle with the result; the receiver cannot stall.
// ----------------------------------------------------------------------------
module disjoint_set_union_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          func,
    input  logic [dsu_pkg::NODE_W-1:0]    node_a,
    input  logic [dsu_pkg::NODE_W-1:0]    node_b,
    output logic                          busy,
    output logic                          done,
    output logic [dsu_pkg::NODE_W-1:0]    root_a,
    output logic [dsu_pkg::NODE_W-1:0]    root_b,
    output logic                          same_set,
    output logic                          merged,
    output logic [dsu_pkg::COUNT_W-1:0]   set_size
);

    typedef enum logic [5:0] {
        ST_CLEAR      = 6'b000001,
        ST_IDLE       = 6'b000010,
        ST_FIND       = 6'b000100,
        ST_COMP       = 6'b001000,
        ST_LINK_CHILD = 6'b010000,
        ST_LINK_TOP   = 6'b100000
    } state_t;

    state_t                        state_reg, state_next;
    logic [dsu_pkg::NODE_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                          done_reg, done_next;

    logic                          func_reg, func_next;
    logic [dsu_pkg::NODE_W-1:0]    node_a_reg, node_a_next;
    logic [dsu_pkg::NODE_W-1:0]    node_b_reg, node_b_next;
    logic                          side_reg, side_next;      // 0: walking a, 1: walking b
    logic [dsu_pkg::NODE_W-1:0]    cur_reg, cur_next;        // walk head, then the root
    logic [dsu_pkg::NODE_W-1:0]    walk_reg, walk_next;
    logic [dsu_pkg::NODE_W-1:0]    ra_reg, ra_next;
    logic [dsu_pkg::RANK_W-1:0]    ra_rank_reg, ra_rank_next;
    logic [dsu_pkg::COUNT_W-1:0]   ra_cnt_reg, ra_cnt_next;
    logic [dsu_pkg::RANK_W-1:0]    rb_rank_reg, rb_rank_next;
    logic [dsu_pkg::COUNT_W-1:0]   rb_cnt_reg, rb_cnt_next;

    logic [dsu_pkg::NODE_W-1:0]    root_a_reg, root_a_next;
    logic [dsu_pkg::NODE_W-1:0]    root_b_reg, root_b_next;
    logic                          same_reg, same_next;
    logic                          merged_reg, merged_next;
    logic [dsu_pkg::COUNT_W-1:0]   size_reg, size_next;

    logic                          ram_we;
    logic [dsu_pkg::NODE_W-1:0]    ram_waddr;
    dsu_pkg::dsu_entry_t           ram_wdata;
    logic [dsu_pkg::NODE_W-1:0]    ram_raddr;
    dsu_pkg::dsu_entry_t           ram_rdata;
    logic [dsu_pkg::ENTRY_W-1:0]   ram_rword;

    // link decision, stable once both walks are done
    logic                          a_is_top;
    logic [dsu_pkg::NODE_W-1:0]    top_node, child_node;
    logic [dsu_pkg::RANK_W-1:0]    top_rank, child_rank;
    logic [dsu_pkg::COUNT_W-1:0]   top_cnt, child_cnt;
    logic [dsu_pkg::COUNT_W:0]     cnt_sum;
    logic [dsu_pkg::COUNT_W-1:0]   cnt_sat;
    logic [dsu_pkg::RANK_W-1:0]    rank_new;
    logic [dsu_pkg::NODE_W-1:0]    walk_start;

    dsu_ram #(
        .WIDTH (dsu_pkg::ENTRY_W),
        .DEPTH (dsu_pkg::NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rword)
    );

    assign ram_rdata = dsu_pkg::dsu_entry_t'(ram_rword);

    assign a_is_top   = ra_rank_reg > rb_rank_reg;
    assign top_node   = a_is_top ? ra_reg      : cur_reg;
    assign child_node = a_is_top ? cur_reg     : ra_reg;
    assign top_rank   = a_is_top ? ra_rank_reg : rb_rank_reg;
    assign child_rank = a_is_top ? rb_rank_reg : ra_rank_reg;
    assign top_cnt    = a_is_top ? ra_cnt_reg  : rb_cnt_reg;
    assign child_cnt  = a_is_top ? rb_cnt_reg  : ra_cnt_reg;
    assign cnt_sum    = {1'b0, top_cnt} + {1'b0, child_cnt};
    assign cnt_sat    = cnt_sum[dsu_pkg::COUNT_W] ? dsu_pkg::COUNT_MAX
                                                  : cnt_sum[dsu_pkg::COUNT_W-1:0];
    assign rank_new   = (top_rank == child_rank && top_rank != dsu_pkg::RANK_MAX)
                        ? top_rank + dsu_pkg::RANK_W'(1) : top_rank;
    assign walk_start = side_reg ? node_b_reg : node_a_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        func_next    = func_reg;
        node_a_next  = node_a_reg;
        node_b_next  = node_b_reg;
        side_next    = side_reg;
        cur_next     = cur_reg;
        walk_next    = walk_reg;
        ra_next      = ra_reg;
        ra_rank_next = ra_rank_reg;
        ra_cnt_next  = ra_cnt_reg;
        rb_rank_next = rb_rank_reg;
        rb_cnt_next  = rb_cnt_reg;
        root_a_next  = root_a_reg;
        root_b_next  = root_b_reg;
        same_next    = same_reg;
        merged_next  = merged_reg;
        size_next    = size_reg;

        ram_we    = 1'b0;
        ram_waddr = walk_reg;
        ram_wdata = ram_rdata;
        ram_raddr = cur_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we           = 1'b1;
                ram_waddr        = clr_cnt_reg;
                ram_wdata.count  = dsu_pkg::COUNT_ONE;
                ram_wdata.rank   = '0;
                ram_wdata.parent = clr_cnt_reg;
                clr_cnt_next     = clr_cnt_reg + dsu_pkg::NODE_W'(1);
                if (clr_cnt_reg == dsu_pkg::NODE_W'(dsu_pkg::NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = node_a;
                if (start)
                begin
                    func_next   = func;
                    node_a_next = node_a;
                    node_b_next = node_b;
                    side_next   = 1'b0;
                    cur_next    = node_a;
                    state_next  = ST_FIND;
                end
            end
            ST_FIND:
            begin
                // data word belongs to cur_reg
                if (ram_rdata.parent == cur_reg)
                begin
                    if (side_reg)
                    begin
                        rb_rank_next = ram_rdata.rank;
                        rb_cnt_next  = ram_rdata.count;
                    end
                    else
                    begin
                        ra_rank_next = ram_rdata.rank;
                        ra_cnt_next  = ram_rdata.count;
                    end
                    walk_next  = walk_start;
                    ram_raddr  = walk_start;
                    state_next = ST_COMP;
                end
                else
                begin
                    cur_next  = ram_rdata.parent;
                    ram_raddr = ram_rdata.parent;
                end
            end
            ST_COMP:
            begin
                // data word belongs to walk_reg; cur_reg holds the root
                if (walk_reg == cur_reg)
                begin
                    if (!side_reg)
                    begin
                        ra_next    = cur_reg;
                        side_next  = 1'b1;
                        cur_next   = node_b_reg;
                        ram_raddr  = node_b_reg;
                        state_next = ST_FIND;
                    end
                    else if (func_reg && ra_reg != cur_reg)
                    begin
                        state_next = ST_LINK_CHILD;
                    end
                    else
                    begin
                        root_a_next = ra_reg;
                        root_b_next = cur_reg;
                        same_next   = ra_reg == cur_reg;
                        merged_next = 1'b0;
                        size_next   = ra_cnt_reg;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = walk_reg;
                    ram_wdata.parent = cur_reg;
                    walk_next        = ram_rdata.parent;
                    ram_raddr        = ram_rdata.parent;
                end
            end
            ST_LINK_CHILD:
            begin
                ram_we           = 1'b1;
                ram_waddr        = child_node;
                ram_wdata.count  = child_cnt;
                ram_wdata.rank   = child_rank;
                ram_wdata.parent = top_node;
                state_next       = ST_LINK_TOP;
            end
            ST_LINK_TOP:
            begin
                ram_we           = 1'b1;
                ram_waddr        = top_node;
                ram_wdata.count  = cnt_sat;
                ram_wdata.rank   = rank_new;
                ram_wdata.parent = top_node;
                root_a_next      = top_node;
                root_b_next      = cur_reg;
                same_next        = 1'b0;
                merged_next      = 1'b1;
                size_next        = cnt_sat;
                done_next        = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        node_a_reg  <= node_a_next;
        node_b_reg  <= node_b_next;
        side_reg    <= side_next;
        cur_reg     <= cur_next;
        walk_reg    <= walk_next;
        ra_reg      <= ra_next;
        ra_rank_reg <= ra_rank_next;
        ra_cnt_reg  <= ra_cnt_next;
        rb_rank_reg <= rb_rank_next;
        rb_cnt_reg  <= rb_cnt_next;
        root_a_reg  <= root_a_next;
        root_b_reg  <= root_b_next;
        same_reg    <= same_next;
        merged_reg  <= merged_next;
        size_reg    <= size_next;
    end

    assign busy     = state_reg != ST_IDLE;
    assign done     = done_reg;
    assign root_a   = root_a_reg;
    assign root_b   = root_b_reg;
    assign same_set = same_reg;
    assign merged   = merged_reg;
    assign set_size = size_reg;

endmodule

@@ verif/dsu_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsu_tb_pkg: request codes shared by the union-find testbench files
// Names the two values of the func port so stimulus and checker agree.
// ----------------------------------------------------------------------------
package dsu_tb_pkg;

    typedef enum logic {
        DSU_QUERY = 1'b0,
        DSU_JOIN  = 1'b1
    } dsu_op_e;

endpackage

@@ verif/dsu_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsu_result_checker: prediction and comparison for the union-find engine
// Keeps its own parent, rank and size tables, replays every accepted request
// on them (root walks with path compression, union by rank) and compares each
// done word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module dsu_result_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        func,
    input  logic [dsu_pkg::NODE_W-1:0]  node_a,
    input  logic [dsu_pkg::NODE_W-1:0]  node_b,
    input  logic                        done,
    input  logic [dsu_pkg::NODE_W-1:0]  root_a,
    input  logic [dsu_pkg::NODE_W-1:0]  root_b,
    input  logic                        same_set,
    input  logic                        merged,
    input  logic [dsu_pkg::COUNT_W-1:0] set_size,
    output int                          mismatches,
    output int                          outstanding,
    output int                          merge_total,
    output int                          largest_set,
    output int                          deepest_walk
);
    import dsu_pkg::*;
    import dsu_tb_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0]  root_a;
        logic [NODE_W-1:0]  root_b;
        logic               same_set;
        logic               merged;
        logic [COUNT_W-1:0] set_size;
    } dsu_outcome_t;

    logic [NODE_W-1:0]  link_of [NODES];
    logic [RANK_W-1:0]  rank_of [NODES];
    logic [COUNT_W-1:0] size_of [NODES];

    dsu_outcome_t predicted_outcomes[$];

    // walk to the root, then point every node on the path straight at it
    function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] from_node);
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] walk;
        logic [NODE_W-1:0] nxt;
        int                steps;
        cur   = from_node;
        steps = 0;
        while (link_of[cur] != cur && steps < NODES) begin
            cur = link_of[cur];
            steps++;
        end
        if (steps > deepest_walk)
            deepest_walk = steps;
        walk  = from_node;
        steps = 0;
        while (walk != cur && steps < NODES) begin
            nxt           = link_of[walk];
            link_of[walk] = cur;
            walk          = nxt;
            steps++;
        end
        return cur;
    endfunction

    function automatic dsu_outcome_t resolve_request(input logic op,
                                                     input logic [NODE_W-1:0] a_in,
                                                     input logic [NODE_W-1:0] b_in);
        logic [NODE_W-1:0]  a_idx;
        logic [NODE_W-1:0]  b_idx;
        logic [NODE_W-1:0]  ra;
        logic [NODE_W-1:0]  rb;
        logic [NODE_W-1:0]  child;
        logic [NODE_W-1:0]  top_root;
        logic [COUNT_W:0]   total;
        dsu_outcome_t       res;
        // indexes past the table fold back into it
        a_idx = NODE_W'(int'(a_in) % NODES);
        b_idx = NODE_W'(int'(b_in) % NODES);
        ra    = find_root(a_idx);
        rb    = find_root(b_idx);
        res.root_b   = rb;
        res.same_set = (ra == rb);
        res.merged   = 1'b0;
        top_root     = ra;
        if (op == DSU_JOIN && ra != rb) begin
            // lower rank goes under; on a tie b's root stays on top
            child    = ra;
            top_root = rb;
            if (rank_of[ra] > rank_of[rb]) begin
                child    = rb;
                top_root = ra;
            end
            link_of[child] = top_root;
            total = {1'b0, size_of[top_root]} + {1'b0, size_of[child]};
            size_of[top_root] = (total > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                            : total[COUNT_W-1:0];
            if (rank_of[child] == rank_of[top_root] && rank_of[top_root] != RANK_MAX)
                rank_of[top_root] = rank_of[top_root] + 1'b1;
            res.merged = 1'b1;
            merge_total++;
        end
        res.root_a   = top_root;
        res.set_size = size_of[top_root];
        if (int'(res.set_size) > largest_set)
            largest_set = int'(res.set_size);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        dsu_outcome_t want;
        int           i;
        if (!rst_n) begin
            for (i = 0; i < NODES; i++) begin
                link_of[i] = NODE_W'(i);
                rank_of[i] = '0;
                size_of[i] = COUNT_ONE;
            end
            predicted_outcomes.delete();
            outstanding <= 0;
        end else begin
            if (done === 1'b1) begin
                if (predicted_outcomes.size() == 0) begin
                    mismatches++;
                    $display("%0t: done word with no request pending, expected none, actual %0d",
                             $time, root_a);
                end else begin
                    want = predicted_outcomes.pop_front();
                    check_field("root_a", 16'(want.root_a), 16'(root_a));
                    check_field("root_b", 16'(want.root_b), 16'(root_b));
                    check_field("same_set", 16'(want.same_set), 16'(same_set));
                    check_field("merged", 16'(want.merged), 16'(merged));
                    check_field("set_size", 16'(want.set_size), 16'(set_size));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                predicted_outcomes.push_back(resolve_request(func, node_a, node_b));
            outstanding <= predicted_outcomes.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the disjoint-set union engine
// Directed joins and queries first, then random segments: local clusters,
// full-range pairs, query sweeps and doubling tree builds, sent in bursts.
// ----------------------------------------------------------------------------
module testbench;
    import dsu_pkg::*;
    import dsu_tb_pkg::*;

    localparam int RANDOM_WORDS = 750;

    logic               clk;
    logic               rst_n  = 1'b0;
    logic               start  = 1'b0;
    logic               func   = 1'b0;
    logic [NODE_W-1:0]  node_a = '0;
    logic [NODE_W-1:0]  node_b = '0;
    logic               busy;
    logic               done;
    logic [NODE_W-1:0]  root_a;
    logic [NODE_W-1:0]  root_b;
    logic               same_set;
    logic               merged;
    logic [COUNT_W-1:0] set_size;

    int mismatches;
    int outstanding;
    int merge_total;
    int largest_set;
    int deepest_walk;
    int sent        = 0;
    int joins_sent  = 0;
    int burst_left  = 4;

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    disjoint_set_union_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .func     (func),
        .node_a   (node_a),
        .node_b   (node_b),
        .busy     (busy),
        .done     (done),
        .root_a   (root_a),
        .root_b   (root_b),
        .same_set (same_set),
        .merged   (merged),
        .set_size (set_size)
    );

    dsu_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .node_a       (node_a),
        .node_b       (node_b),
        .done         (done),
        .root_a       (root_a),
        .root_b       (root_b),
        .same_set     (same_set),
        .merged       (merged),
        .set_size     (set_size),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .merge_total  (merge_total),
        .largest_set  (largest_set),
        .deepest_walk (deepest_walk)
    );

    // start stays high across a burst; a gap opens after its last word or in a drain
    task automatic issue(input dsu_op_e op, input logic [NODE_W-1:0] a,
                         input logic [NODE_W-1:0] b);
        start  <= 1'b1;
        func   <= op;
        node_a <= a;
        node_b <= b;
        do @(posedge clk); while (busy !== 1'b0);
        sent++;
        if (op == DSU_JOIN)
            joins_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [NODE_W-1:0] base;
        int                mode;
        int                seg;
        int                n;
        int                tree_nodes;
        int                stride;
        int                i;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: table corners, ties, higher rank on either side, same set
        issue(DSU_QUERY, 10'd0, 10'd0);
        issue(DSU_QUERY, 10'd0, 10'd1023);
        issue(DSU_JOIN, 10'd0, 10'd1023);
        issue(DSU_JOIN, 10'd1023, 10'd0);
        issue(DSU_JOIN, 10'd1, 10'd2);
        issue(DSU_JOIN, 10'd1, 10'd0);
        issue(DSU_JOIN, 10'd3, 10'd1);
        issue(DSU_JOIN, 10'd1023, 10'd5);
        issue(DSU_QUERY, 10'd1, 10'd3);
        issue(DSU_JOIN, 10'd512, 10'd512);
        issue(DSU_JOIN, 10'h155, 10'h2AA);
        issue(DSU_JOIN, 10'd100, 10'd101);
        issue(DSU_JOIN, 10'd102, 10'd103);
        issue(DSU_JOIN, 10'd100, 10'd102);
        issue(DSU_JOIN, 10'd100, 10'd0);
        issue(DSU_QUERY, 10'd100, 10'd1);
        issue(DSU_QUERY, 10'd1022, 10'd1023);
        issue(DSU_JOIN, 10'd600, 10'd1023);
        issue(DSU_JOIN, 10'h2AA, 10'd102);
        issue(DSU_QUERY, 10'd600, 10'd600);
        issue(DSU_QUERY, 10'h155, 10'd3);
        drain();

        n = 0;
        while (n < RANDOM_WORDS) begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(8, 30);
            base = NODE_W'($urandom);
            case (mode)
                0: begin
                    // small cluster: mostly joins, sets grow and collide
                    for (i = 0; i < seg; i++) begin
                        issue(($urandom_range(0, 3) != 0) ? DSU_JOIN : DSU_QUERY,
                              NODE_W'(base + $urandom_range(0, 15)),
                              NODE_W'(base + $urandom_range(0, 15)));
                        n++;
                    end
                end
                1: begin
                    for (i = 0; i < seg; i++) begin
                        issue($urandom_range(0, 1) ? DSU_JOIN : DSU_QUERY,
                              NODE_W'($urandom), NODE_W'($urandom));
                        n++;
                    end
                end
                2: begin
                    for (i = 0; i < seg; i++) begin
                        issue(DSU_QUERY, NODE_W'(base + $urandom_range(0, 63)),
                              NODE_W'(base + $urandom_range(0, 63)));
                        n++;
                    end
                end
                default: begin
                    // pairwise doubling builds equal-rank trees, deep walks
                    tree_nodes = 1 << $urandom_range(2, 5);
                    for (stride = 1; stride < tree_nodes; stride = stride * 2) begin
                        for (i = 0; i < tree_nodes; i = i + 2 * stride) begin
                            if ($urandom_range(0, 1))
                                issue(DSU_JOIN, NODE_W'(base + i),
                                      NODE_W'(base + i + stride));
                            else
                                issue(DSU_JOIN, NODE_W'(base + i + stride),
                                      NODE_W'(base + i));
                            n++;
                        end
                    end
                    issue(DSU_QUERY, NODE_W'(base + $urandom_range(0, tree_nodes - 1)),
                          NODE_W'(base + $urandom_range(0, tree_nodes - 1)));
                    n++;
                end
            endcase
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (64) @(posedge clk);
        $display("Ran %0d requests (%0d joins): %0d merges, largest set %0d nodes,",
                 sent, joins_sent, merge_total, largest_set);
        $display("longest root walk %0d links.", deepest_walk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
